@@ rtl/core/segment_tree_range_max_macros.svh @@
// Assertion macros for the segment tree range maximum block.
`ifndef SEGMENT_TREE_RANGE_MAX_MACROS_SVH
`define SEGMENT_TREE_RANGE_MAX_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define STRM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define STRM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/strm_pkg.sv @@
// Package with shared widths and action codes of the segment tree block.
`default_nettype none

package strm_pkg;

    localparam int ACT_W    = 2;
    localparam int IDX_W    = 10;
    localparam int IN_VAL_W = 17;
    localparam int CNT_W    = 11;

    localparam logic [ACT_W-1:0] ACT_WRITE   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REBUILD = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY   = 2'd2;

    localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

endpackage

`default_nettype wire

@@ rtl/core/strm_if.sv @@
// Valid/ready channel interfaces for request and result words.
`default_nettype none

interface strm_in_if import strm_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [ACT_W-1:0]           action;
    logic [IDX_W-1:0]           left_index;
    logic [IDX_W-1:0]           right_index;
    logic signed [IN_VAL_W-1:0] leaf_value;

    modport source (output valid, action, left_index, right_index, leaf_value,
                    input ready);
    modport sink   (input valid, action, left_index, right_index, leaf_value,
                    output ready);
endinterface

interface strm_out_if import strm_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [IN_VAL_W-1:0] range_max;

    modport source (output valid, range_max, input ready);
    modport sink   (input valid, range_max, output ready);
endinterface

`default_nettype wire

@@ rtl/core/strm_ram.sv @@
// Generic RAM: one write port, two registered read ports, read-before-write.
`default_nettype none

module strm_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    output logic [WIDTH-1:0]         o_rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_a <= r_mem[i_rd_addr_a];
        r_rd_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

`default_nettype wire

@@ rtl/core/segment_tree_range_max.sv @@
// Top level of the segment tree range maximum block.
// Requests arrive on i_item (valid/ready); query results leave on o_result.
// i_cfg_we/i_cfg_data set the element count; write it only while idle.
// After reset the tree store is swept to empty (-1), one node per cycle over
// every node, with i_item.ready low; config writes are still taken.
// Write: stores one leaf in the accept cycle if left_index is in range; no result.
// Rebuild: after accept, leaves at index count and above are emptied, then the
// parents are rebuilt from the last one down to node 1, one node per cycle
// through the two RAM read ports, followed by a drain state; no result.
// Query: reads two nodes per tree level, walking up from both leaves; the result
// word is then loaded into the output register, and the next request can be
// taken in the cycle in which that word becomes valid. An empty or inverted
// range skips the walk and goes straight to loading the result.
// The result sits in an output register; a stalled receiver holds it, and
// new requests are taken meanwhile. A second query that finishes while the
// register is still full waits until it drains.
`default_nettype none

`include "segment_tree_range_max_macros.svh"

module segment_tree_range_max import strm_pkg::*; #(
    parameter int LEAF_COUNT = 1024,
    parameter int VALUE_BITS = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_data,
    strm_in_if.sink          i_item,
    strm_out_if.source       o_result
);

    localparam int NODE_COUNT = 2 * LEAF_COUNT;
    localparam int NODE_BITS  = $clog2(NODE_COUNT);
    localparam int K_BITS     = NODE_BITS - 1;

    localparam logic [NODE_BITS-1:0] LAST_NODE    = NODE_BITS'(NODE_COUNT - 1);
    localparam logic [K_BITS-1:0]    FIRST_PARENT = K_BITS'(LEAF_COUNT - 1);

    typedef logic signed [VALUE_BITS-1:0] t_value;
    localparam t_value EMPTY = '1;

    typedef enum logic [7:0] {
        S_CLEAR   = 8'b0000_0001,
        S_IDLE    = 8'b0000_0010,
        S_EMPTY   = 8'b0000_0100,
        S_REBUILD = 8'b0000_1000,
        S_DRAIN   = 8'b0001_0000,
        S_QUERY   = 8'b0010_0000,
        S_DONE    = 8'b0100_0000
    } t_state;

    t_state                     r_state, n_state;
    logic [CNT_W-1:0]           r_count;
    logic [NODE_BITS-1:0]       r_node, n_node;
    logic [K_BITS-1:0]          r_k, n_k;
    logic [NODE_BITS-1:0]       r_lo, n_lo;
    logic [NODE_BITS-1:0]       r_hi, n_hi;
    t_value                     r_best, n_best;
    logic                       r_rd_valid, n_rd_valid;
    logic                       r_use_lo, n_use_lo;
    logic                       r_use_hi, n_use_hi;
    logic                       r_wb_valid, n_wb_valid;
    logic [K_BITS-1:0]          r_wb_addr, n_wb_addr;
    logic                       r_fwd_a, r_fwd_b;
    t_value                     r_fwd_data;
    logic                       r_out_valid, n_out_valid;
    logic signed [IN_VAL_W-1:0] r_out_data, n_out_data;

    logic                 wr_en;
    logic [NODE_BITS-1:0] wr_addr;
    t_value               wr_data;
    logic [NODE_BITS-1:0] rd_addr_a, rd_addr_b;
    t_value               q_a, q_b, node_a, node_b;
    t_value               wb_data, fold_a, fold_b;

    logic                 accept;
    logic [31:0]          left_ext, right_ext, right_sat, count_ext;
    logic                 left_ok, query_ok, has_empty;
    logic [NODE_BITS-1:0] leaf_node, hi_node, empty_start;
    logic [NODE_BITS:0]   lo_inc;
    logic [NODE_BITS-1:0] hi_dec, lo_next, hi_next;
    logic                 walk_step, out_load;

    strm_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (NODE_COUNT)
    ) u_tree_ram (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_addr_a (rd_addr_a),
        .o_rd_data_a (q_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_b (q_b)
    );

    assign i_item.ready       = (r_state == S_IDLE);
    assign accept             = i_item.valid && i_item.ready;
    assign o_result.valid     = r_out_valid;
    assign o_result.range_max = r_out_data;

    always_comb begin
        left_ext    = 32'(i_item.left_index);
        right_ext   = 32'(i_item.right_index);
        right_sat   = (right_ext >= 32'(LEAF_COUNT)) ? 32'(LEAF_COUNT - 1) : right_ext;
        left_ok     = left_ext < 32'(LEAF_COUNT);
        query_ok    = left_ok && (left_ext <= right_sat);
        leaf_node   = NODE_BITS'(32'(LEAF_COUNT) + left_ext);
        hi_node     = NODE_BITS'(32'(LEAF_COUNT) + right_sat);
        count_ext   = 32'(r_count);
        has_empty   = count_ext < 32'(LEAF_COUNT);
        empty_start = NODE_BITS'(32'(LEAF_COUNT) + count_ext);
    end

    always_comb begin
        lo_inc  = {1'b0, r_lo} + {{NODE_BITS{1'b0}}, 1'b1};
        lo_next = lo_inc[NODE_BITS:1];
        hi_dec  = r_hi - {{(NODE_BITS-1){1'b0}}, 1'b1};
        hi_next = {1'b0, hi_dec[NODE_BITS-1:1]};
    end

    // forward a write that lands on an address read in the same cycle
    assign node_a  = r_fwd_a ? r_fwd_data : q_a;
    assign node_b  = r_fwd_b ? r_fwd_data : q_b;
    assign wb_data = (node_a > node_b) ? node_a : node_b;
    assign fold_a  = (r_rd_valid && r_use_lo && (node_a > r_best)) ? node_a : r_best;
    assign fold_b  = (r_rd_valid && r_use_hi && (node_b > fold_a)) ? node_b : fold_a;

    assign walk_step = (r_state == S_QUERY) && (r_lo <= r_hi);
    assign out_load  = (r_state == S_DONE) && (!r_out_valid || o_result.ready);

    always_comb begin
        if (r_state == S_REBUILD) begin
            rd_addr_a = {r_k, 1'b0};
            rd_addr_b = {r_k, 1'b1};
        end else begin
            rd_addr_a = r_lo;
            rd_addr_b = r_hi;
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_node;
        wr_data = EMPTY;
        if ((r_state == S_CLEAR) || (r_state == S_EMPTY)) begin
            wr_en = 1'b1;
        end else if (r_wb_valid) begin
            wr_en   = 1'b1;
            wr_addr = {1'b0, r_wb_addr};
            wr_data = wb_data;
        end else if (accept && (i_item.action == ACT_WRITE) && left_ok) begin
            wr_en   = 1'b1;
            wr_addr = leaf_node;
            wr_data = VALUE_BITS'(i_item.leaf_value);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_node      = r_node;
        n_k         = r_k;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_best      = r_best;
        n_rd_valid  = 1'b0;
        n_use_lo    = r_use_lo;
        n_use_hi    = r_use_hi;
        n_wb_valid  = 1'b0;
        n_wb_addr   = r_wb_addr;
        n_out_valid = r_out_valid && !o_result.ready;
        n_out_data  = r_out_data;
        case (r_state)
            S_CLEAR: begin
                n_node = r_node + {{(NODE_BITS-1){1'b0}}, 1'b1};
                if (r_node == LAST_NODE) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_item.action == ACT_REBUILD) begin
                        if (has_empty) begin
                            n_node  = empty_start;
                            n_state = S_EMPTY;
                        end else begin
                            n_k     = FIRST_PARENT;
                            n_state = S_REBUILD;
                        end
                    end else if (i_item.action == ACT_QUERY) begin
                        n_best  = EMPTY;
                        n_lo    = leaf_node;
                        n_hi    = hi_node;
                        n_state = query_ok ? S_QUERY : S_DONE;
                    end
                end
            end
            S_EMPTY: begin
                n_node = r_node + {{(NODE_BITS-1){1'b0}}, 1'b1};
                if (r_node == LAST_NODE) begin
                    n_k     = FIRST_PARENT;
                    n_state = S_REBUILD;
                end
            end
            S_REBUILD: begin
                n_wb_valid = 1'b1;
                n_wb_addr  = r_k;
                n_k        = r_k - {{(K_BITS-1){1'b0}}, 1'b1};
                if (r_k == {{(K_BITS-1){1'b0}}, 1'b1}) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_IDLE;
            end
            S_QUERY: begin
                n_best = fold_b;
                if (r_lo <= r_hi) begin
                    n_rd_valid = 1'b1;
                    n_use_lo   = r_lo[0];
                    n_use_hi   = !r_hi[0];
                    n_lo       = lo_next;
                    n_hi       = hi_next;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = IN_VAL_W'(r_best);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_count     <= COUNT_RESET;
            r_node      <= '0;
            r_rd_valid  <= 1'b0;
            r_wb_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd_a     <= 1'b0;
            r_fwd_b     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_node      <= n_node;
            r_rd_valid  <= n_rd_valid;
            r_wb_valid  <= n_wb_valid;
            r_out_valid <= n_out_valid;
            r_fwd_a     <= wr_en && (wr_addr == rd_addr_a);
            r_fwd_b     <= wr_en && (wr_addr == rd_addr_b);
            if (i_cfg_we) begin
                r_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_best     <= n_best;
        r_use_lo   <= n_use_lo;
        r_use_hi   <= n_use_hi;
        r_wb_addr  <= n_wb_addr;
        r_fwd_data <= wr_data;
        r_out_data <= n_out_data;
    end

    `STRM_ASSERT_NOW(a_wb_parent, r_wb_valid, r_wb_addr != '0, "write-back to node zero")
    `STRM_ASSERT_NEXT(a_rebuild_wb, r_state == S_REBUILD, r_wb_valid, "missing write-back")
    `STRM_ASSERT_NOW(a_query_bound, walk_step, r_hi <= LAST_NODE, "query node out of range")
    `STRM_ASSERT_NEXT(a_done_load, out_load, (r_state == S_IDLE) && r_out_valid, "word not loaded")

endmodule

`default_nettype wire
